[src/por_pkg.sv]
// ----------------------------------------------------------------------------
// por_pkg
// Shared types, widths and helper functions of the polygon outline rasterizer.
// ----------------------------------------------------------------------------
package por_pkg;

	localparam int COORD_W    = 24;
	localparam int SCALE_W    = 16;
	localparam int SCREEN_W   = 13;
	localparam int COLOR_W    = 32;
	localparam int PIX_W      = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int COORD_FRAC = 8;
	localparam int SLOPE_FRAC = 16;
	localparam int SCALE_FRAC = 8;

	localparam int MUL_A_W = COORD_W + 1;
	localparam int MUL_B_W = SLOPE_FRAC + 2;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam int DIV_W     = COORD_W + 1;
	localparam int QUOT_W    = SLOPE_FRAC + 1;
	localparam int DIV_CNT_W = $clog2(QUOT_W + 1);
	localparam int POS_W     = COORD_W - COORD_FRAC;
	localparam int ICPT_W    = PROD_W;
	localparam int ACC_W     = ICPT_W + 1;
	localparam int MINOR_W   = ACC_W - SLOPE_FRAC - COORD_FRAC;
	localparam int XSUM_W    = PROD_W - SCALE_FRAC + 1;

	localparam logic [SCREEN_W-1:0] MAX_SCREEN = 13'd4096;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_NEXT  = 2'd1,
		OP_CLOSE = 2'd2,
		OP_STEP  = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCALE_X    = 3'd0,
		CFG_SCALE_Y    = 3'd1,
		CFG_OFFSET_X   = 3'd2,
		CFG_OFFSET_Y   = 3'd3,
		CFG_SCREEN_W   = 3'd4,
		CFG_SCREEN_H   = 3'd5,
		CFG_DRAW_COLOR = 3'd6
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XF_X,
		ST_XF_Y,
		ST_XF_W,
		ST_EDGE,
		ST_DIV,
		ST_INT_MUL,
		ST_INT_ADD,
		ST_STEP_MUL,
		ST_STEP_ADD,
		ST_RESP
	} state_t;

	// floor(p / 2^8) + offset, saturated to the coordinate range
	function automatic logic signed [COORD_W-1:0] sat_coord(
		input logic signed [PROD_W-1:0]  p,
		input logic signed [COORD_W-1:0] off
	);
		logic signed [XSUM_W-1:0] s;
		s = $signed(p[PROD_W-1:SCALE_FRAC]) + off;
		if (s > $signed(XSUM_W'(8388607))) begin
			sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (s < -$signed(XSUM_W'(8388608))) begin
			sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			sat_coord = s[COORD_W-1:0];
		end
	endfunction

	// integer part of a coordinate, truncated toward zero
	function automatic logic signed [POS_W-1:0] trunc_coord(
		input logic signed [COORD_W-1:0] a
	);
		logic signed [COORD_W-1:0] t;
		t = a + (a[COORD_W-1] ? COORD_W'((1 << COORD_FRAC) - 1) : '0);
		trunc_coord = t[COORD_W-1:COORD_FRAC];
	endfunction

endpackage

[src/por_if.sv]
// ----------------------------------------------------------------------------
// por_vtx_if / por_pix_if
// Valid/ready channels for vertex commands and emitted pixels.
// ----------------------------------------------------------------------------
interface por_vtx_if;
	import por_pkg::*;
	logic                      valid;
	logic                      ready;
	opcode_t                   opcode;
	logic signed [COORD_W-1:0] vert_x;
	logic signed [COORD_W-1:0] vert_y;
	modport source(output valid, opcode, vert_x, vert_y, input ready);
	modport sink(input valid, opcode, vert_x, vert_y, output ready);
endinterface

interface por_pix_if;
	import por_pkg::*;
	logic               valid;
	logic               ready;
	logic               pixel_valid;
	logic [PIX_W-1:0]   pixel_x;
	logic [PIX_W-1:0]   pixel_y;
	logic [COLOR_W-1:0] pixel_color;
	logic               edge_done;
	modport source(output valid, pixel_valid, pixel_x, pixel_y, pixel_color, edge_done,
		input ready);
	modport sink(input valid, pixel_valid, pixel_x, pixel_y, pixel_color, edge_done,
		output ready);
endinterface

[src/por_mul.sv]
// ----------------------------------------------------------------------------
// por_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module por_mul (
	input  logic                               clk,
	input  logic signed [por_pkg::MUL_A_W-1:0] a,
	input  logic signed [por_pkg::MUL_B_W-1:0] b,
	output logic signed [por_pkg::PROD_W-1:0]  prod_s1
);
	import por_pkg::*;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end
endmodule

[src/por_div.sv]
// ----------------------------------------------------------------------------
// por_div
// Restoring divider, one quotient bit per cycle: (num * 2^16) / den with num <= den.
// ----------------------------------------------------------------------------
module por_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [por_pkg::DIV_W-1:0]         num,
	input  logic [por_pkg::DIV_W-1:0]         den,
	output logic                              done,
	output logic [por_pkg::QUOT_W-1:0]        quot
);
	import por_pkg::*;

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DIV_W:0]       rem_q;
	logic [DIV_W-1:0]     den_q;
	logic [QUOT_W-1:0]    quot_q;
	logic                 ge;
	logic [DIV_W:0]       diff;
	logic [DIV_W:0]       rem_nx;

	assign ge     = rem_q >= {1'b0, den_q};
	assign diff   = rem_q - {1'b0, den_q};
	assign rem_nx = ge ? diff : rem_q;
	assign done   = busy_q && (cnt_q == '0);
	assign quot   = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= DIV_CNT_W'(QUOT_W);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q  <= {rem_nx[DIV_W-1:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], ge};
		end
	end
endmodule

[src/polygon_outline_rasterizer.sv]
// ----------------------------------------------------------------------------
// polygon_outline_rasterizer
// Polygon outline to pixels: vertex transform, edge setup, per-step pixel output.
// ----------------------------------------------------------------------------
// One transaction is taken at a time; every command gives one result transaction.
// A step passes once through the shared multiplier, then the add and clip; a step
// with no active edge goes straight to the response. Begin uses two multiplies for
// the transform. Next and close run edge setup: the bit-serial slope divider, then
// one more multiply for the intercept; next first does the transform.
// A result waits in the output register while the next command is accepted.
module polygon_outline_rasterizer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [por_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [por_pkg::CFG_DATA_W-1:0] cfg_wdata,
	por_vtx_if.sink                        vtx,
	por_pix_if.source                      pix
);
	import por_pkg::*;

	// configuration
	logic signed [SCALE_W-1:0] scale_x_q, scale_y_q;
	logic signed [COORD_W-1:0] offset_x_q, offset_y_q;
	logic [SCREEN_W-1:0]       screen_w_q, screen_h_q;
	logic [COLOR_W-1:0]        color_q;

	// sequencer and polygon state
	state_t                    state_q, state_nx;
	opcode_t                   op_q;
	logic signed [COORD_W-1:0] vx_q, vy_q, tx_q;
	logic signed [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic signed [COORD_W-1:0] e0x_q, e0y_q, e1x_q, e1y_q;
	logic signed [COORD_W-1:0] a0_q, b0_q;
	logic                      x_major_q, num_neg_q, den_zero_q, edge_active_q;
	logic signed [MUL_B_W-1:0] slope_q;
	logic signed [ICPT_W-1:0]  intercept_q;
	logic signed [POS_W-1:0]   step_pos_q, step_end_q;

	// result staging and output register
	logic               res_pv_q, res_done_q;
	logic [PIX_W-1:0]   res_px_q, res_py_q;
	logic [COLOR_W-1:0] res_col_q;
	logic               out_v_q;
	logic               out_pv_q, out_done_q;
	logic [PIX_W-1:0]   out_px_q, out_py_q;
	logic [COLOR_W-1:0] out_col_q;

	// shared units
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod_s1;
	logic                      div_start, div_done;
	logic [QUOT_W-1:0]         div_quot;

	// edge setup
	logic signed [DIV_W-1:0]   dx, dy, num;
	logic [DIV_W-1:0]          adx, ady, num_mag, den;
	logic                      xm, swap;
	logic signed [COORD_W-1:0] a0, a1, b0;
	logic signed [COORD_W-1:0] ty;

	// step
	logic signed [ACC_W-1:0]   acc, acc_t;
	logic signed [MINOR_W-1:0] minor, px, py;
	logic [SCREEN_W-1:0]       vis_w, vis_h;
	logic                      on_screen;
	logic                      in_xfer, out_free;

	por_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	por_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_mag),
		.den    (den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign in_xfer  = vtx.valid && vtx.ready;
	assign out_free = !out_v_q || pix.ready;

	always_comb begin
		dx   = $signed({e1x_q[COORD_W-1], e1x_q}) - $signed({e0x_q[COORD_W-1], e0x_q});
		dy   = $signed({e1y_q[COORD_W-1], e1y_q}) - $signed({e0y_q[COORD_W-1], e0y_q});
		adx  = dx[DIV_W-1] ? DIV_W'(-dx) : DIV_W'(dx);
		ady  = dy[DIV_W-1] ? DIV_W'(-dy) : DIV_W'(dy);
		xm   = (dx != '0) && (ady <= adx);
		swap = xm ? (e0x_q > e1x_q) : (e0y_q > e1y_q);
		if (xm) begin
			a0  = swap ? e1x_q : e0x_q;
			a1  = swap ? e0x_q : e1x_q;
			b0  = swap ? e1y_q : e0y_q;
			num = swap ? -dy : dy;
			den = adx;
		end else begin
			a0  = swap ? e1y_q : e0y_q;
			a1  = swap ? e0y_q : e1y_q;
			b0  = swap ? e1x_q : e0x_q;
			num = swap ? -dx : dx;
			den = ady;
		end
		num_mag = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
	end

	always_comb begin
		ty    = sat_coord(prod_s1, offset_y_q);
		acc   = $signed({prod_s1[ACC_W-COORD_FRAC-1:0], {COORD_FRAC{1'b0}}}) + intercept_q;
		acc_t = acc + (acc[ACC_W-1] ? ACC_W'((1 << (SLOPE_FRAC + COORD_FRAC)) - 1) : '0);
		minor = acc_t[ACC_W-1:SLOPE_FRAC+COORD_FRAC];
		px    = x_major_q ? MINOR_W'(step_pos_q) : minor;
		py    = x_major_q ? minor : MINOR_W'(step_pos_q);
		vis_w = (screen_w_q > MAX_SCREEN) ? MAX_SCREEN : screen_w_q;
		vis_h = (screen_h_q > MAX_SCREEN) ? MAX_SCREEN : screen_h_q;
		on_screen = !px[MINOR_W-1] && !py[MINOR_W-1]
			&& (px < $signed({{(MINOR_W-SCREEN_W){1'b0}}, vis_w}))
			&& (py < $signed({{(MINOR_W-SCREEN_W){1'b0}}, vis_h}));
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (vtx.valid) begin
					unique case (vtx.opcode)
						OP_BEGIN, OP_NEXT: state_nx = ST_XF_X;
						OP_CLOSE:          state_nx = ST_EDGE;
						OP_STEP:           state_nx = edge_active_q ? ST_STEP_MUL : ST_RESP;
						default:           state_nx = ST_IDLE;
					endcase
				end
			end
			ST_XF_X:     state_nx = ST_XF_Y;
			ST_XF_Y:     state_nx = ST_XF_W;
			ST_XF_W:     state_nx = (op_q == OP_BEGIN) ? ST_RESP : ST_EDGE;
			ST_EDGE:     state_nx = ST_DIV;
			ST_DIV:      state_nx = div_done ? ST_INT_MUL : ST_DIV;
			ST_INT_MUL:  state_nx = ST_INT_ADD;
			ST_INT_ADD:  state_nx = ST_RESP;
			ST_STEP_MUL: state_nx = ST_STEP_ADD;
			ST_STEP_ADD: state_nx = ST_RESP;
			ST_RESP:     state_nx = out_free ? ST_IDLE : ST_RESP;
			default:     state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		vtx.ready = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			ST_IDLE:     vtx.ready = 1'b1;
			ST_XF_X: begin
				mul_a = MUL_A_W'(vx_q);
				mul_b = MUL_B_W'(scale_x_q);
			end
			ST_XF_Y: begin
				mul_a = MUL_A_W'(vy_q);
				mul_b = MUL_B_W'(scale_y_q);
			end
			ST_EDGE:     div_start = 1'b1;
			ST_INT_MUL: begin
				mul_a = MUL_A_W'(a0_q);
				mul_b = slope_q;
			end
			ST_STEP_MUL: begin
				mul_a = MUL_A_W'(step_pos_q);
				mul_b = slope_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q  <= SCALE_W'(256);
			scale_y_q  <= SCALE_W'(256);
			offset_x_q <= '0;
			offset_y_q <= '0;
			screen_w_q <= MAX_SCREEN;
			screen_h_q <= MAX_SCREEN;
			color_q    <= '1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_SCALE_X:    scale_x_q  <= cfg_wdata[SCALE_W-1:0];
				CFG_SCALE_Y:    scale_y_q  <= cfg_wdata[SCALE_W-1:0];
				CFG_OFFSET_X:   offset_x_q <= cfg_wdata[COORD_W-1:0];
				CFG_OFFSET_Y:   offset_y_q <= cfg_wdata[COORD_W-1:0];
				CFG_SCREEN_W:   screen_w_q <= cfg_wdata[SCREEN_W-1:0];
				CFG_SCREEN_H:   screen_h_q <= cfg_wdata[SCREEN_W-1:0];
				CFG_DRAW_COLOR: color_q    <= cfg_wdata[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_x_q     <= '0;
			first_y_q     <= '0;
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			x_major_q     <= 1'b0;
			slope_q       <= '0;
			intercept_q   <= '0;
			step_pos_q    <= '0;
			step_end_q    <= '0;
			edge_active_q <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			if ((state_q == ST_RESP) && out_free) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && pix.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (vtx.opcode == OP_CLOSE)) begin
						prev_x_q <= first_x_q;
						prev_y_q <= first_y_q;
					end
				end
				ST_XF_W: begin
					prev_x_q <= tx_q;
					prev_y_q <= ty;
					if (op_q == OP_BEGIN) begin
						first_x_q     <= tx_q;
						first_y_q     <= ty;
						edge_active_q <= 1'b0;
					end
				end
				ST_EDGE: begin
					x_major_q  <= xm;
					step_pos_q <= trunc_coord(a0);
					step_end_q <= trunc_coord(a1);
				end
				ST_DIV: begin
					if (div_done) begin
						if (den_zero_q) begin
							slope_q <= '0;
						end else if (num_neg_q) begin
							slope_q <= -$signed({1'b0, div_quot});
						end else begin
							slope_q <= $signed({1'b0, div_quot});
						end
					end
				end
				ST_INT_ADD: begin
					intercept_q   <= $signed({b0_q, {SLOPE_FRAC{1'b0}}}) - prod_s1;
					edge_active_q <= 1'b1;
				end
				ST_STEP_ADD: begin
					if (step_pos_q >= step_end_q) begin
						edge_active_q <= 1'b0;
					end else begin
						step_pos_q <= step_pos_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					op_q       <= vtx.opcode;
					vx_q       <= vtx.vert_x;
					vy_q       <= vtx.vert_y;
					res_pv_q   <= 1'b0;
					res_px_q   <= '0;
					res_py_q   <= '0;
					res_col_q  <= '0;
					res_done_q <= (vtx.opcode == OP_BEGIN)
						|| ((vtx.opcode == OP_STEP) && !edge_active_q);
					e0x_q      <= prev_x_q;
					e0y_q      <= prev_y_q;
					e1x_q      <= first_x_q;
					e1y_q      <= first_y_q;
				end
			end
			ST_XF_Y: tx_q <= sat_coord(prod_s1, offset_x_q);
			ST_XF_W: begin
				e0x_q <= prev_x_q;
				e0y_q <= prev_y_q;
				e1x_q <= tx_q;
				e1y_q <= ty;
			end
			ST_EDGE: begin
				a0_q       <= a0;
				b0_q       <= b0;
				num_neg_q  <= num[DIV_W-1];
				den_zero_q <= (den == '0);
			end
			ST_STEP_ADD: begin
				res_pv_q   <= on_screen;
				res_px_q   <= on_screen ? px[PIX_W-1:0] : '0;
				res_py_q   <= on_screen ? py[PIX_W-1:0] : '0;
				res_col_q  <= on_screen ? color_q : '0;
				res_done_q <= (step_pos_q >= step_end_q);
			end
			ST_RESP: begin
				if (out_free) begin
					out_pv_q   <= res_pv_q;
					out_px_q   <= res_px_q;
					out_py_q   <= res_py_q;
					out_col_q  <= res_col_q;
					out_done_q <= res_done_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign pix.valid       = out_v_q;
	assign pix.pixel_valid = out_pv_q;
	assign pix.pixel_x     = out_px_q;
	assign pix.pixel_y     = out_py_q;
	assign pix.pixel_color = out_col_q;
	assign pix.edge_done   = out_done_q;
endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for polygon_outline_rasterizer. Vertex and step
// transactions are sent over the vertex channel. Every accepted transaction
// advances a local outline predictor that queues the pixel it should produce.
// Each pixel transaction is checked against the oldest queued pixel. The run
// sweeps register settings, idle and stall patterns, and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
	import por_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 40;

	typedef struct packed {
		logic               pixel_valid;
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
		logic [COLOR_W-1:0] pixel_color;
		logic               edge_done;
	} pixel_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	por_vtx_if vtx ();
	por_pix_if pix ();

	polygon_outline_rasterizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.vtx       (vtx.sink),
		.pix       (pix.source)
	);

	// register copy
	logic signed [SCALE_W-1:0] scale_x, scale_y;
	logic signed [COORD_W-1:0] offset_x, offset_y;
	logic [SCREEN_W-1:0]       screen_w, screen_h;
	logic [COLOR_W-1:0]        draw_color;
	logic [CFG_DATA_W-1:0]     cfg_vals [7];

	// outline state copy
	logic signed [COORD_W-1:0] first_x, first_y, prev_x, prev_y;
	logic                      x_major;
	longint                    slope, intercept;
	logic signed [16:0]        step_pos, step_end;
	logic                      edge_active;

	pixel_t pixels_expected [$];
	int     errors;
	int     items_sent;
	int     idle_pct;
	int     stall_pct;
	bit     hold_off;
	int     quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint trunc_sh(longint v, int k);
		return (v >= 0) ? (v >>> k) : -((-v) >>> k);
	endfunction

	function automatic longint floor_sh(longint v, int k);
		return (v >= 0) ? (v >>> k) : -(((-v) + (longint'(1) <<< k) - 1) >>> k);
	endfunction

	function automatic logic signed [COORD_W-1:0] transform(longint v, longint s, longint o);
		longint r;
		r = floor_sh(v * s, SCALE_FRAC) + o;
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return r[COORD_W-1:0];
	endfunction

	function automatic void apply_reg(int idx, logic [CFG_DATA_W-1:0] v);
		case (cfg_reg_t'(idx))
			CFG_SCALE_X:    scale_x = v[SCALE_W-1:0];
			CFG_SCALE_Y:    scale_y = v[SCALE_W-1:0];
			CFG_OFFSET_X:   offset_x = v[COORD_W-1:0];
			CFG_OFFSET_Y:   offset_y = v[COORD_W-1:0];
			CFG_SCREEN_W:   screen_w = v[SCREEN_W-1:0];
			CFG_SCREEN_H:   screen_h = v[SCREEN_W-1:0];
			CFG_DRAW_COLOR: draw_color = v;
			default: ;
		endcase
	endfunction

	function automatic void setup_edge(longint x0, longint y0, longint x1, longint y1);
		longint dx, dy, adx, ady, a0, a1, b0, num, den;
		dx = x1 - x0;
		dy = y1 - y0;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		if (dx != 0 && ady <= adx) begin
			x_major = 1'b1;
			if (x0 > x1) begin
				a0 = x1; a1 = x0; b0 = y1; num = y0 - y1; den = x0 - x1;
			end else begin
				a0 = x0; a1 = x1; b0 = y0; num = dy; den = dx;
			end
		end else begin
			x_major = 1'b0;
			if (y0 > y1) begin
				a0 = y1; a1 = y0; b0 = x1; num = x0 - x1; den = y0 - y1;
			end else begin
				a0 = y0; a1 = y1; b0 = x0; num = dx; den = dy;
			end
		end
		slope = (den == 0) ? 0 : (num * (longint'(1) <<< SLOPE_FRAC)) / den;
		intercept = b0 * (longint'(1) <<< SLOPE_FRAC) - slope * a0;
		step_pos = trunc_sh(a0, COORD_FRAC);
		step_end = trunc_sh(a1, COORD_FRAC);
		edge_active = 1'b1;
	endfunction

	function automatic pixel_t predict_pixel(opcode_t op, logic signed [COORD_W-1:0] vx_in,
		logic signed [COORD_W-1:0] vy_in);
		pixel_t r;
		logic signed [COORD_W-1:0] vx, vy;
		longint minor, px, py, w, h;
		r = '0;
		case (op)
			OP_BEGIN, OP_NEXT: begin
				vx = transform(vx_in, scale_x, offset_x);
				vy = transform(vy_in, scale_y, offset_y);
				if (op == OP_BEGIN) begin
					first_x = vx;
					first_y = vy;
					edge_active = 1'b0;
					r.edge_done = 1'b1;
				end else begin
					setup_edge(prev_x, prev_y, vx, vy);
				end
				prev_x = vx;
				prev_y = vy;
			end
			OP_CLOSE: begin
				setup_edge(prev_x, prev_y, first_x, first_y);
				prev_x = first_x;
				prev_y = first_y;
			end
			default: begin
				if (!edge_active) begin
					r.edge_done = 1'b1;
				end else begin
					minor = trunc_sh(slope * longint'(step_pos) * (longint'(1) <<< COORD_FRAC)
						+ intercept, SLOPE_FRAC + COORD_FRAC);
					px = x_major ? longint'(step_pos) : minor;
					py = x_major ? minor : longint'(step_pos);
					w = screen_w > MAX_SCREEN ? MAX_SCREEN : screen_w;
					h = screen_h > MAX_SCREEN ? MAX_SCREEN : screen_h;
					if (px >= 0 && px < w && py >= 0 && py < h) begin
						r.pixel_valid = 1'b1;
						r.pixel_x = px[PIX_W-1:0];
						r.pixel_y = py[PIX_W-1:0];
						r.pixel_color = draw_color;
					end
					if (step_pos >= step_end) begin
						edge_active = 1'b0;
						r.edge_done = 1'b1;
					end else begin
						step_pos = step_pos + 1;
					end
				end
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// pixel checker and output ready driver
	always @(posedge clk) begin
		pixel_t exp_p;
		if (pix.valid && pix.ready) begin
			if (pixels_expected.size() == 0) begin
				$display("%0t: unexpected pixel transaction, expected none actual %0h",
					$time, {pix.pixel_valid, pix.pixel_x, pix.pixel_y, pix.pixel_color,
					pix.edge_done});
				errors++;
			end else begin
				exp_p = pixels_expected.pop_front();
				check_field("pixel_valid", exp_p.pixel_valid, pix.pixel_valid);
				check_field("pixel_x", exp_p.pixel_x, pix.pixel_x);
				check_field("pixel_y", exp_p.pixel_y, pix.pixel_y);
				check_field("pixel_color", exp_p.pixel_color, pix.pixel_color);
				check_field("edge_done", exp_p.edge_done, pix.edge_done);
			end
		end
		pix.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if ((vtx.valid && vtx.ready) || (pix.valid && pix.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_item(opcode_t op, logic signed [COORD_W-1:0] x,
		logic signed [COORD_W-1:0] y);
		vtx.valid <= 1'b1;
		vtx.opcode <= op;
		vtx.vert_x <= x;
		vtx.vert_y <= y;
		@(posedge clk);
		while (!vtx.ready) @(posedge clk);
		pixels_expected.push_back(predict_pixel(op, x, y));
		items_sent++;
		if ($urandom_range(99) < idle_pct) begin
			vtx.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
	endtask

	task automatic wait_empty();
		vtx.valid <= 1'b0;
		while (pixels_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_config();
		cfg_wr_en <= 1'b1;
		for (int i = 0; i < 7; i++) begin
			cfg_index <= CFG_IDX_W'(i);
			cfg_wdata <= cfg_vals[i];
			@(posedge clk);
			apply_reg(i, cfg_vals[i]);
		end
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord(int span_px);
		return COORD_W'(int'($urandom_range(2 * span_px * 256)) - span_px * 256);
	endfunction

	task automatic send_steps(int cap);
		int left, cnt;
		left = edge_active ? int'(step_end - step_pos) + 1 : 0;
		if ($urandom_range(9) < 7) cnt = left;
		else cnt = $urandom_range(left + 2);
		if (cnt > cap) cnt = cap;
		repeat (cnt) send_item(OP_STEP, COORD_W'($urandom()), COORD_W'($urandom()));
	endtask

	task automatic send_polygon(int span_px);
		send_item(OP_BEGIN, rand_coord(span_px), rand_coord(span_px));
		repeat ($urandom_range(1, 5)) begin
			send_item(OP_NEXT, rand_coord(span_px), rand_coord(span_px));
			send_steps(60);
		end
		send_item(OP_CLOSE, COORD_W'($urandom()), COORD_W'($urandom()));
		send_steps(60);
	endtask

	task automatic send_random(int count, int span_px);
		int target;
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(9) == 0) begin
				send_item(opcode_t'($urandom_range(3)), COORD_W'($urandom()),
					COORD_W'($urandom()));
			end else begin
				send_polygon(span_px);
			end
		end
	endtask

	task automatic test_directed();
		send_item(OP_STEP, '0, '0);
		send_item(OP_BEGIN, '0, '0);
		send_item(OP_NEXT, 24'sd1664, 24'sd832);
		repeat (7) send_item(OP_STEP, '0, '0);
		send_item(OP_NEXT, 24'sd1664, 24'sd1536);
		repeat (2) send_item(OP_STEP, '0, '0);
		send_item(OP_NEXT, 24'sd1664, 24'sd1536);
		repeat (2) send_item(OP_STEP, '0, '0);
		send_item(OP_CLOSE, '0, '0);
		send_item(OP_STEP, '0, '0);
		send_item(OP_BEGIN, -24'sd1280, -24'sd1280);
		send_item(OP_NEXT, 24'sd512, 24'sd256);
		repeat (2) send_item(OP_STEP, '0, '0);
		send_item(OP_BEGIN, 24'sh7FFFFF, 24'sh7FFFFF);
		send_item(OP_NEXT, 24'sh800000, 24'sh800000);
		send_item(OP_STEP, '0, '0);
		wait_empty();
	endtask

	task automatic test_idle_modes();
		int pct [4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{16, 16}};
		for (int m = 0; m < 4; m++) begin
			idle_pct = pct[m][0];
			stall_pct = pct[m][1];
			send_random(120, 48);
		end
		idle_pct = 0;
		stall_pct = 0;
		wait_empty();
	endtask

	task automatic test_config_sweep();
		logic [CFG_DATA_W-1:0] sets [5][7];
		sets[0] = '{32'hFFFF8000, 32'h00007FFF, 32'hFF800000, 32'h007FFFFF, 32'd0, 32'd1,
			32'h00000000};
		sets[1] = '{32'd128, 32'hFFFFFF00, 32'd5120, 32'd12800, 32'd8191, 32'd4096,
			$urandom()};
		sets[2] = '{32'd256, 32'd256, 32'd2560, 32'd1280, 32'd64, 32'd48, $urandom()};
		sets[3] = '{32'd4096, 32'd1, 32'h00400000, 32'hFFC00000, 32'd1, 32'd8191,
			$urandom()};
		sets[4] = '{32'd256, 32'd256, 32'd0, 32'd0, 32'd4096, 32'd4096, 32'hFFFFFFFF};
		for (int s = 0; s < 5; s++) begin
			cfg_vals = sets[s];
			write_config();
			idle_pct = (s % 2) ? 16 : 0;
			stall_pct = (s % 2) ? 16 : 0;
			send_random(40, 24);
			wait_empty();
		end
		idle_pct = 0;
		stall_pct = 0;
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		fork
			begin
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				send_item(OP_BEGIN, '0, '0);
				send_item(OP_NEXT, 24'sd10240, 24'sd2560);
				repeat (30) send_item(OP_STEP, '0, '0);
			end
		join
		wait_empty();
	endtask

	task automatic test_drain_pause();
		repeat (4) begin
			send_polygon(16);
			wait_empty();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		vtx.valid = 1'b0;
		vtx.opcode = OP_BEGIN;
		vtx.vert_x = '0;
		vtx.vert_y = '0;
		pix.ready = 1'b0;
		errors = 0;
		items_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_off = 1'b0;
		quiet_cycles = 0;
		scale_x = 16'sd256;
		scale_y = 16'sd256;
		offset_x = '0;
		offset_y = '0;
		screen_w = 13'd4096;
		screen_h = 13'd4096;
		draw_color = 32'hFFFFFFFF;
		first_x = '0;
		first_y = '0;
		prev_x = '0;
		prev_y = '0;
		x_major = 1'b0;
		slope = 0;
		intercept = 0;
		step_pos = '0;
		step_end = '0;
		edge_active = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		test_directed();
		test_idle_modes();
		test_config_sweep();
		test_backpressure();
		test_drain_pause();

		wait_empty();
		if (errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

[files.f]
src/por_pkg.sv
src/por_if.sv
src/por_mul.sv
src/por_div.sv
src/polygon_outline_rasterizer.sv
tb/sv/testbench.sv
